[sv/differential_thrust_mixer_top_defines.svh]
// Assertion macros for the differential thrust mixer.
// Included by differential_thrust_mixer_top; no other dependencies.
`ifndef DIFFERENTIAL_THRUST_MIXER_TOP_DEFINES_SVH
`define DIFFERENTIAL_THRUST_MIXER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DTM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DTM_ASSERT_NEVER(name, expr, msg) \
  `DTM_ASSERT(name, !(expr), msg)
`else
`define DTM_ASSERT(name, prop, msg)
`define DTM_ASSERT_NEVER(name, expr, msg)
`endif
`endif

[sv/dtm_pkg.sv]
// Shared types and constants for the differential thrust mixer.
// No dependencies.
package dtm_pkg;

  localparam int unsigned SPD_W     = 16;
  localparam int unsigned SUM_W     = SPD_W + 2;
  localparam int unsigned REM_W     = 18;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_MIX_MODE = 2'd1
  } dtm_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_DIV,
    ST_FIN
  } dtm_state_e;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic res_load;
    logic res_div;
  } dtm_cmd_t;

  typedef struct packed {
    logic enable;
    logic need_div;
    logic div_last;
  } dtm_status_t;

endpackage

[sv/differential_thrust_mixer_top.sv]
// Differential thrust mixer top level: controller plus datapath.
// Depends on dtm_pkg, dtm_ctrl, dtm_dp and the assertion macro header.
//
//   channel  signals                              direction
//   in       in_valid_i/in_ready_o, kind, speed   sink
//   out      out_valid_o/out_ready_i, left, right source
//   cfg      cfg_valid_i/cfg_ready_o, index, data sink, always ready
//
// Results without division: the item is captured, mixed in ST_MIX and loaded into the
// output register once it is free; no new item is taken before that.
// Normalize with division: ST_MIX loads the divider, ST_DIV runs the restoring divider
// that retires one quotient bit per cycle for both sides, and ST_FIN loads the result.
// A finished result waits in the output register; the next item is taken meanwhile.
// Reset sets enable, clears mix mode and both held speeds.
`include "differential_thrust_mixer_top_defines.svh"
module differential_thrust_mixer_top import dtm_pkg::*; #(
  parameter int unsigned FRAC_BITS = 14,
  parameter int unsigned DEAD_ZONE = 164
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    kind_i,
  input  logic signed [SPD_W-1:0] speed_value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [SPD_W-1:0] left_speed_o,
  output logic signed [SPD_W-1:0] right_speed_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic                    cfg_data_i
);

  dtm_cmd_t    cmd;
  dtm_status_t status;

  assign cfg_ready_o = 1'b1;

  dtm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dtm_dp #(
    .FRAC_BITS (FRAC_BITS),
    .DEAD_ZONE (DEAD_ZONE)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .kind_i        (kind_i),
    .speed_value_i (speed_value_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .left_speed_o  (left_speed_o),
    .right_speed_o (right_speed_o)
  );

  `DTM_ASSERT(a_no_overwrite, cmd.res_load |-> (!out_valid_o || out_ready_i), "result overwritten")
  `DTM_ASSERT(a_busy_after_load, cmd.load |=> !in_ready_o, "item taken while busy")
  `DTM_ASSERT(a_valid_from_load, $rose(out_valid_o) |-> $past(cmd.res_load), "stray result")
  `DTM_ASSERT_NEVER(a_step_idle, cmd.div_step && in_ready_o, "divider runs while idle")

endmodule

[sv/dtm_dp.sv]
// Datapath: config registers, held speeds, mixer and two-lane restoring divider.
// Depends on dtm_pkg.
module dtm_dp import dtm_pkg::*; #(
  parameter int unsigned FRAC_BITS = 14,
  parameter int unsigned DEAD_ZONE = 164
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic                        cfg_data_i,
  input  logic                        kind_i,
  input  logic signed [SPD_W-1:0]     speed_value_i,
  input  dtm_cmd_t                    cmd_i,
  output dtm_status_t                 status_o,
  output logic signed [SPD_W-1:0]     left_speed_o,
  output logic signed [SPD_W-1:0]     right_speed_o
);

  localparam int unsigned MW = (FRAC_BITS + 2 > REM_W) ? FRAC_BITS + 2 : REM_W;
  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned CW = $clog2(QW + 1);
  localparam logic [MW-1:0] ONE_U = MW'(1) << FRAC_BITS;
  localparam logic [SUM_W-1:0] DZ = SUM_W'(DEAD_ZONE);

  function automatic logic [SUM_W-1:0] mag(logic [SUM_W-1:0] v);
    return v[SUM_W-1] ? (SUM_W'(0) - v) : v;
  endfunction

  logic enable_q, mode_q;
  logic [SPD_W-1:0] f_q, t_q;
  logic [SUM_W-1:0] den_q;
  logic [REM_W-1:0] rem_l_q, rem_r_q;
  logic [QW-1:0]    ql_q, qr_q;
  logic             neg_l_q, neg_r_q;
  logic [CW-1:0]    cnt_q;
  logic [SPD_W-1:0] res_l_q, res_r_q;

  // clamp of the incoming command
  logic signed [MW-1:0] sx;
  logic [SPD_W-1:0]     clamped;

  always_comb begin
    sx = {{(MW-SPD_W){speed_value_i[SPD_W-1]}}, speed_value_i};
    if (sx > $signed(ONE_U)) begin
      clamped = ONE_U[SPD_W-1:0];
    end else if (sx < -$signed(ONE_U)) begin
      clamped = SPD_W'(0) - ONE_U[SPD_W-1:0];
    end else begin
      clamped = sx[SPD_W-1:0];
    end
  end

  // mixer
  logic [SUM_W-1:0] f17, t17, s, d, s_h, d_h, mf, mt, al, ar;
  logic             al_big, ar_big, sel_l, norm_path;
  logic [SPD_W-1:0] mix_l, mix_r;

  always_comb begin
    f17    = {{(SUM_W-SPD_W){f_q[SPD_W-1]}}, f_q};
    t17    = {{(SUM_W-SPD_W){t_q[SPD_W-1]}}, t_q};
    s      = f17 + t17;
    d      = f17 - t17;
    s_h    = s + SUM_W'(s[SUM_W-1]);
    d_h    = d + SUM_W'(d[SUM_W-1]);
    mf     = mag(f17);
    mt     = mag(t17);
    al     = mag(s);
    ar     = mag(d);
    al_big = MW'(al) > ONE_U;
    ar_big = MW'(ar) > ONE_U;
    sel_l  = al_big && (al > ar);
    norm_path = 1'b0;
    if (mf < DZ) begin
      mix_l = t_q;
      mix_r = SPD_W'(0) - t_q;
    end else if (mt < DZ) begin
      mix_l = f_q;
      mix_r = f_q;
    end else if (!mode_q) begin
      mix_l = s_h[SPD_W:1];
      mix_r = d_h[SPD_W:1];
    end else begin
      mix_l     = s[SPD_W-1:0];
      mix_r     = d[SPD_W-1:0];
      norm_path = 1'b1;
    end
  end

  // divider step
  logic             ge_l, ge_r;
  logic [REM_W-1:0] den_ext, diff_l, diff_r;
  logic [SPD_W-1:0] q16_l, q16_r, div_l, div_r;

  always_comb begin
    den_ext = REM_W'(den_q);
    ge_l    = rem_l_q >= den_ext;
    ge_r    = rem_r_q >= den_ext;
    diff_l  = ge_l ? (rem_l_q - den_ext) : rem_l_q;
    diff_r  = ge_r ? (rem_r_q - den_ext) : rem_r_q;
    q16_l   = SPD_W'(ql_q);
    q16_r   = SPD_W'(qr_q);
    div_l   = neg_l_q ? (SPD_W'(0) - q16_l) : q16_l;
    div_r   = neg_r_q ? (SPD_W'(0) - q16_r) : q16_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      mode_q   <= 1'b0;
      f_q      <= '0;
      t_q      <= '0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (dtm_cfg_e'(cfg_index_i))
          CFG_ENABLE:   enable_q <= cfg_data_i;
          CFG_MIX_MODE: mode_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        if (kind_i) begin
          t_q <= clamped;
        end else begin
          f_q <= clamped;
        end
      end
      if (cmd_i.div_init) begin
        cnt_q <= CW'(QW);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      den_q   <= sel_l ? al : ar;
      rem_l_q <= REM_W'(al);
      rem_r_q <= REM_W'(ar);
      neg_l_q <= s[SUM_W-1];
      neg_r_q <= d[SUM_W-1];
      ql_q    <= '0;
      qr_q    <= '0;
    end else if (cmd_i.div_step) begin
      rem_l_q <= {diff_l[REM_W-2:0], 1'b0};
      rem_r_q <= {diff_r[REM_W-2:0], 1'b0};
      ql_q    <= {ql_q[QW-2:0], ge_l};
      qr_q    <= {qr_q[QW-2:0], ge_r};
    end
    if (cmd_i.res_load) begin
      res_l_q <= cmd_i.res_div ? div_l : mix_l;
      res_r_q <= cmd_i.res_div ? div_r : mix_r;
    end
  end

  assign status_o.enable   = enable_q;
  assign status_o.need_div = norm_path && (sel_l || ar_big);
  assign status_o.div_last = (cnt_q == CW'(1));
  assign left_speed_o      = res_l_q;
  assign right_speed_o     = res_r_q;

endmodule

[sv/dtm_ctrl.sv]
// Controller: sequences capture, mix, divide and result hand-off.
// Depends on dtm_pkg.
module dtm_ctrl import dtm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  dtm_status_t status_i,
  output dtm_cmd_t    cmd_o
);

  dtm_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i && status_i.enable) state_d = ST_MIX;
      ST_MIX: begin
        if (status_i.need_div) begin
          state_d = ST_DIV;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV:  if (status_i.div_last) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i && status_i.enable;
      end
      ST_MIX: begin
        cmd_o.div_init = status_i.need_div;
        cmd_o.res_load = !status_i.need_div && out_free;
      end
      ST_DIV: cmd_o.div_step = 1'b1;
      ST_FIN: begin
        cmd_o.res_load = out_free;
        cmd_o.res_div  = 1'b1;
      end
      default: ;
    endcase
    out_valid_d = cmd_o.res_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
